[sv/assert_macros.svh]
// Assertion macros shared by the table's RTL files.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/ukst_pkg.sv]
// Shared types and constants for the unordered key set table.
// No dependencies; imported by the controller, datapath and top level.
package ukst_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_CONTAINS = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_GET      = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SWAP,
        S_GET,
        S_RESP
    } state_t;

    // Source of the memory read address
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_NEXT,
        RD_LAST,
        RD_POS
    } rd_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    wr_add;
        logic    wr_swap;
        logic    clear;
        logic    scan_start;
        logic    scan_next;
        rd_sel_t rd_sel;
        logic    set_found;
        logic    set_full;
        logic    set_range;
        logic    load_value;
        logic    load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic    req_valid;
        opcode_t op;
        logic    full;
        logic    empty;
        logic    get_ok;
        logic    match;
        logic    scan_last;
        logic    out_free;
    } dp_stat_t;

endpackage

[sv/ukst_req_if.sv]
// Request channel: one beat carries an opcode, a key and a position.
// No dependencies.
interface ukst_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [31:0] key;
    logic [5:0] position;

    modport source (output valid, output opcode, output key, output position, input ready);
    modport sink   (input valid, input opcode, input key, input position, output ready);
endinterface

[sv/ukst_rsp_if.sv]
// Response channel: one beat per request with found, value, count and status.
// No dependencies.
interface ukst_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] entry_value;
    logic [6:0]  entry_count;
    logic [1:0]  status;

    modport source (output valid, output found, output entry_value, output entry_count,
                    output status, input ready);
    modport sink   (input valid, input found, input entry_value, input entry_count,
                    input status, output ready);
endinterface

[sv/unordered_key_set_table.sv]
// Unordered key set table: append, swap-remove, contains, clear, get by index.
// Each accepted beat is dispatched, then contains/remove scan the entries, a remove hit swaps in
// the last entry and a good get reads its entry before the result is registered.
// One item at a time: the next beat is taken in the cycle after the result is registered; the scan
// reads one entry per cycle from the single-read entry RAM.
// Reset empties the table and the output register; entry RAM contents are not cleared.
module unordered_key_set_table (
    input  logic       clk,
    input  logic       rst_n,
    ukst_req_if.sink   req,
    ukst_rsp_if.source rsp
);
    import ukst_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     ctrl_ready;

    assign req.ready = ctrl_ready;

    ukst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd),
        .ready (ctrl_ready)
    );

    ukst_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

[sv/ukst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ukst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/ukst_datapath.sv]
// Datapath: request latch, fill count, scan index, entry RAM and result register.
// Depends on ukst_pkg, ukst_req_if, ukst_rsp_if, ukst_ram and assert_macros.svh.
`include "assert_macros.svh"
module ukst_datapath (
    input  logic               clk,
    input  logic               rst_n,
    ukst_req_if.sink           req,
    ukst_rsp_if.source         rsp,
    input  ukst_pkg::dp_cmd_t  cmd,
    output ukst_pkg::dp_stat_t stat
);
    import ukst_pkg::*;

    logic [2:0]           op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [5:0]           pos_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [KEY_WIDTH-1:0] value_reg, value_next;
    status_t              status_reg, status_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg;
    logic [31:0]          out_value_reg;
    logic [6:0]           out_count_reg;
    status_t              out_status_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr, last_idx;
    logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;

    assign last_idx = ADDR_W'(count_reg - 1'b1);

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg  <= req.opcode;
            key_reg <= KEY_WIDTH'(req.key);
            pos_reg <= req.position;
        end
    end

    // Fill count and scan index
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.wr_add)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.wr_swap)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_next)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    // Entry memory ports
    always_comb
    begin
        ram_we    = cmd.wr_add | cmd.wr_swap;
        ram_waddr = cmd.wr_swap ? idx_reg : ADDR_W'(count_reg);
        ram_wdata = cmd.wr_swap ? ram_rdata : key_reg;
        case (cmd.rd_sel)
            RD_NEXT: ram_raddr = idx_reg + 1'b1;
            RD_LAST: ram_raddr = last_idx;
            RD_POS:  ram_raddr = ADDR_W'(pos_reg);
            default: ram_raddr = '0;
        endcase
    end

    ukst_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Per-item result fields
    always_comb
    begin
        found_next  = found_reg;
        value_next  = value_reg;
        status_next = status_reg;
        if (cmd.load_req)
        begin
            found_next  = 1'b0;
            value_next  = '0;
            status_next = ST_OK;
        end
        else
        begin
            if (cmd.set_found)
            begin
                found_next = 1'b1;
            end
            if (cmd.set_full)
            begin
                status_next = ST_FULL;
            end
            if (cmd.set_range)
            begin
                status_next = ST_RANGE;
            end
            if (cmd.load_value)
            begin
                value_next = ram_rdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // Output register: holds a finished beat until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_found_reg  <= found_reg;
            out_value_reg  <= 32'(value_reg);
            out_count_reg  <= 7'(count_reg);
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.entry_value = out_value_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.status      = out_status_reg;

    // Status towards the controller
    always_comb
    begin
        stat.req_valid = req.valid;
        stat.op        = opcode_t'(op_reg);
        stat.full      = (count_reg >= CNT_W'(CAPACITY));
        stat.empty     = (count_reg == '0);
        stat.get_ok    = (CNT_W'(pos_reg) < count_reg);
        stat.match     = (ram_rdata == key_reg);
        stat.scan_last = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
        stat.out_free  = !out_valid_reg || rsp.ready;
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `ASSERT_IMPLIES(a_add_room, cmd.wr_add, !stat.full, "append into a full table")
    `ASSERT_NEXT(a_swap_shrinks, cmd.wr_swap, (count_reg + 1'b1) == $past(count_reg), "swap without count decrement")

endmodule

[sv/ukst_ctrl.sv]
// Controller: sequences dispatch, scan, swap, read and response for one item.
// Depends on ukst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ukst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  ukst_pkg::dp_stat_t stat,
    output ukst_pkg::dp_cmd_t  cmd,
    output logic               ready
);
    import ukst_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_REMOVE, OP_CONTAINS: state_next = stat.empty ? S_RESP : S_SCAN;
                    OP_GET:                 state_next = stat.get_ok ? S_GET : S_RESP;
                    default:                state_next = S_RESP;
                endcase
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    state_next = (stat.op == OP_REMOVE) ? S_SWAP : S_RESP;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_SWAP:  state_next = S_RESP;
            S_GET:   state_next = S_RESP;
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd   = '0;
        ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ready        = 1'b1;
                cmd.load_req = stat.req_valid;
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_ADD:
                    begin
                        cmd.set_full = stat.full;
                        cmd.wr_add   = !stat.full;
                    end
                    OP_REMOVE, OP_CONTAINS:
                    begin
                        cmd.scan_start = !stat.empty;
                        cmd.rd_sel     = RD_ZERO;
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    OP_GET:
                    begin
                        cmd.set_range = !stat.get_ok;
                        cmd.rd_sel    = RD_POS;
                    end
                    default:
                    begin
                        cmd.rd_sel = RD_ZERO;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    cmd.set_found = 1'b1;
                    cmd.rd_sel    = RD_LAST;
                end
                else if (!stat.scan_last)
                begin
                    cmd.scan_next = 1'b1;
                    cmd.rd_sel    = RD_NEXT;
                end
            end
            S_SWAP:  cmd.wr_swap    = 1'b1;
            S_GET:   cmd.load_value = 1'b1;
            S_RESP:  cmd.load_out   = stat.out_free;
            default: cmd            = '0;
        endcase
    end

    `ASSERT_NEXT(a_accept_dispatch, ready && stat.req_valid, state_reg == S_DISPATCH, "accepted beat not dispatched")
    `ASSERT_IMPLIES(a_out_room, cmd.load_out, stat.out_free, "result loaded over a waiting beat")
    `ASSERT_IMPLIES(a_swap_after_scan, state_reg == S_SWAP, $past(state_reg) == S_SCAN, "swap not preceded by scan")

endmodule

[tb/unordered_key_set_table_test.sv]
// Self-checking testbench for the unordered key set table: a directed table, then random beats.
// Each accepted request is run through a local table model and the response beats are compared.
// Depends on ukst_pkg, ukst_req_if, ukst_rsp_if and unordered_key_set_table.
`timescale 1ns / 100ps

module unordered_key_set_table_test;
    import ukst_pkg::*;

    // Opcodes the table treats as no-ops
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    localparam int DIRECTED_ROWS   = 25;
    localparam int BEATS_PER_PHASE = 160;
    localparam int HOLD_CYCLES     = 300;
    localparam int KEY_POOL_DEPTH  = 16;

    typedef struct packed {
        logic        found;
        logic [31:0] value;
        logic [6:0]  count;
        status_t     status;
    } table_result_t;

    // One request beat; pinned rows carry their response typed in
    typedef struct packed {
        logic [2:0]    op;
        logic [31:0]   key;
        logic [5:0]    pos;
        logic          pinned;
        table_result_t want;
    } req_row_t;

    typedef enum {MIX_ALL, FILL_UP} stim_mode_t;

    localparam table_result_t NONE = '0;

    localparam req_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty table
        '{OP_GET,      32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd0, ST_RANGE}},
        '{OP_REMOVE,   32'h0000_0005, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd0, ST_OK}},
        '{OP_CONTAINS, 32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd0, ST_OK}},
        '{OP_CLEAR,    32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd0, ST_OK}},
        // extremes of the key, with a duplicate
        '{OP_ADD,      32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd1, ST_OK}},
        '{OP_ADD,      32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd2, ST_OK}},
        '{OP_ADD,      32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd3, ST_OK}},
        '{OP_ADD,      32'h8000_0001, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd4, ST_OK}},
        '{OP_GET,      32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd4, ST_OK}},
        '{OP_GET,      32'h0000_0000, 6'd1,  1'b1, '{1'b0, 32'hFFFF_FFFF, 7'd4, ST_OK}},
        '{OP_GET,      32'h0000_0000, 6'd3,  1'b1, '{1'b0, 32'h8000_0001, 7'd4, ST_OK}},
        // index at and past the count, then a present and an absent key
        '{OP_GET,      32'h0000_0000, 6'd4,  1'b1, '{1'b0, 32'h0000_0000, 7'd4, ST_RANGE}},
        '{OP_GET,      32'hFFFF_FFFF, 6'd63, 1'b1, '{1'b0, 32'h0000_0000, 7'd4, ST_RANGE}},
        '{OP_CONTAINS, 32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b1, 32'h0000_0000, 7'd4, ST_OK}},
        '{OP_CONTAINS, 32'h7FFF_FFFF, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd4, ST_OK}},
        // remove takes the first duplicate, last entry moves into its slot
        '{OP_REMOVE,   32'hFFFF_FFFF, 6'd0,  1'b0, NONE},
        '{OP_GET,      32'h0000_0000, 6'd1,  1'b0, NONE},
        '{OP_REMOVE,   32'h0000_0000, 6'd0,  1'b0, NONE},
        '{OP_CONTAINS, 32'hFFFF_FFFF, 6'd0,  1'b0, NONE},
        // spare opcodes leave everything alone
        '{OP_SPARE_LO,  32'hFFFF_FFFF, 6'd63, 1'b1, '{1'b0, 32'h0000_0000, 7'd2, ST_OK}},
        '{OP_SPARE_MID, 32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd2, ST_OK}},
        '{OP_SPARE_HI,  32'hA5A5_5A5A, 6'd21, 1'b1, '{1'b0, 32'h0000_0000, 7'd2, ST_OK}},
        // absent key, then clear and refill
        '{OP_REMOVE,   32'h1234_5678, 6'd0,  1'b0, NONE},
        '{OP_CLEAR,    32'hFFFF_FFFF, 6'd63, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, ST_OK}},
        '{OP_ADD,      32'hA5A5_A5A5, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd1, ST_OK}}
    };

    logic clk;
    logic rst_n;

    ukst_req_if req_ch ();
    ukst_rsp_if rsp_ch ();

    unordered_key_set_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Local copy of the table
    logic [31:0] shadow_keys [CAPACITY];
    int          held;

    table_result_t pending [$];
    req_row_t      cur_row;
    logic [31:0]   key_pool [$];

    int          send_idle_pct;
    int          rcv_idle_pct;
    int unsigned holds_asked;
    int unsigned holds_taken;
    int          hold_left;
    int          live_beats;
    int          full_probes;
    int          fails;
    int          results_seen;
    int          refusals_seen;
    int          range_seen;
    int          hits_seen;

    always #4 clk = ~clk;

    // Apply one request to the local table and work out its response
    function automatic table_result_t table_apply(logic [2:0] op, logic [31:0] key,
                                                  logic [5:0] pos);
        table_result_t res;
        int            i;
        bit            hit;
        res = '0;
        res.status = ST_OK;
        hit = 1'b0;
        case (op)
            OP_ADD:
            begin
                if (held >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    shadow_keys[held] = key;
                    held++;
                end
            end
            OP_REMOVE, OP_CONTAINS:
            begin
                for (i = 0; i < held && !hit; i++)
                begin
                    if (shadow_keys[i] == key)
                    begin
                        hit = 1'b1;
                        if (op == OP_REMOVE)
                        begin
                            shadow_keys[i] = shadow_keys[held - 1];
                            held--;
                        end
                    end
                end
                res.found = hit;
            end
            OP_CLEAR:
                held = 0;
            OP_GET:
            begin
                if (int'(pos) < held)
                    res.value = shadow_keys[pos];
                else
                    res.status = ST_RANGE;
            end
            default: ;
        endcase
        res.count = held[6:0];
        return res;
    endfunction

    // Random request; keys lean on recently added ones so lookups hit
    function automatic req_row_t pick_random(stim_mode_t mode);
        req_row_t    r;
        int unsigned roll;
        int unsigned key_roll;
        r = '0;
        roll = $urandom_range(99);
        if (mode == FILL_UP || roll < 30)
            r.op = OP_ADD;
        else if (roll < 50)
            r.op = OP_REMOVE;
        else if (roll < 70)
            r.op = OP_CONTAINS;
        else if (roll < 73)
            r.op = OP_CLEAR;
        else if (roll < 95)
            r.op = OP_GET;
        else
        begin
            case ($urandom_range(2))
                0: r.op = OP_SPARE_LO;
                1: r.op = OP_SPARE_MID;
                default: r.op = OP_SPARE_HI;
            endcase
        end

        key_roll = $urandom_range(99);
        if (key_roll < 55 && key_pool.size() > 0)
            r.key = key_pool[$urandom_range(key_pool.size() - 1)];
        else if (key_roll < 62)
            r.key = '0;
        else if (key_roll < 69)
            r.key = '1;
        else
            r.key = $urandom;

        if (held > 0 && $urandom_range(4) != 0)
            r.pos = 6'($urandom_range(held - 1));
        else
            r.pos = 6'($urandom_range(63));

        if (r.op == OP_ADD)
        begin
            if (key_pool.size() < KEY_POOL_DEPTH)
                key_pool.push_back(r.key);
            else
                key_pool[$urandom_range(KEY_POOL_DEPTH - 1)] = r.key;
        end
        if (mode == FILL_UP && held >= CAPACITY)
            full_probes++;
        if (r.op <= OP_GET)
            live_beats++;
        return r;
    endfunction

    // Offer one beat after a random gap; returns once it is taken
    task automatic next_beat(input bit use_row, input req_row_t row, input stim_mode_t mode);
        req_row_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        @(negedge clk);
        r = use_row ? row : pick_random(mode);
        cur_row         = r;
        req_ch.opcode   = r.op;
        req_ch.key      = r.key;
        req_ch.position = r.pos;
        req_ch.valid    = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Sender stops offering until every response is in
    task automatic drain;
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    // Predict on each accepted request beat
    always @(posedge clk)
    begin
        table_result_t res;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            res = table_apply(req_ch.opcode, req_ch.key, req_ch.position);
            pending.push_back(cur_row.pinned ? cur_row.want : res);
        end
    end

    // Compare each response beat with the oldest prediction
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (rsp_ch.status == ST_FULL)
                refusals_seen++;
            if (rsp_ch.status == ST_RANGE)
                range_seen++;
            if (rsp_ch.found)
                hits_seen++;
            if (pending.size() == 0)
            begin
                $error("response beat with nothing pending");
                fails++;
            end
            else
            begin
                want = pending.pop_front();
                if (rsp_ch.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
                    fails++;
                end
                if (rsp_ch.entry_value !== want.value)
                begin
                    $error("entry_value: expected %h, got %h", want.value, rsp_ch.entry_value);
                    fails++;
                end
                if (rsp_ch.entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, rsp_ch.entry_count);
                    fails++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fails++;
                end
            end
        end
    end

    // Response side back-pressure, with the occasional long hold-off
    always @(negedge clk)
    begin
        if (holds_taken != holds_asked)
        begin
            holds_taken = holds_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready = 1'b0;
        end
        else
            rsp_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
    end

    // Stimulus
    initial
    begin
        int phase;
        int target;
        clk             = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.opcode   = OP_ADD;
        req_ch.key      = '0;
        req_ch.position = '0;
        rsp_ch.ready    = 1'b0;
        cur_row         = '0;
        held            = 0;
        holds_asked     = 0;
        holds_taken     = 0;
        hold_left       = 0;
        live_beats      = 0;
        full_probes     = 0;
        fails           = 0;
        results_seen    = 0;
        refusals_seen   = 0;
        range_seen      = 0;
        hits_seen       = 0;
        send_idle_pct   = 21;
        rcv_idle_pct    = 60;
        for (int i = 0; i < CAPACITY; i++)
            shadow_keys[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            next_beat(1'b1, DIRECTED[i], MIX_ALL);
        drain();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 21;
                    rcv_idle_pct  = 60;
                end
                1:
                begin
                    send_idle_pct = 60;
                    rcv_idle_pct  = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                end
            endcase
            target = live_beats + BEATS_PER_PHASE;

            // fill to capacity and knock on the full table three times
            full_probes = 0;
            while (full_probes < 3)
                next_beat(1'b0, '0, FILL_UP);

            // long response stall while requests keep coming
            if (phase == 0)
                holds_asked++;

            while (live_beats < target)
                next_beat(1'b0, '0, MIX_ALL);
            drain();
        end

        repeat (CAPACITY + 8) @(posedge clk);
        $display("Ran %0d response beats: %0d full refusals, %0d out-of-range gets, %0d hits.",
                 results_seen, refusals_seen, range_seen, hits_seen);
        if (fails == 0 && pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
